### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and codes of the postfix stack evaluator: opcodes, status
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic [2:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_PUSH   = 3'd0;
  localparam opcode_t OP_ADD    = 3'd1;
  localparam opcode_t OP_SUB    = 3'd2;
  localparam opcode_t OP_MUL    = 3'd3;
  localparam opcode_t OP_DIV    = 3'd4;
  localparam opcode_t OP_FINISH = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_DIVZERO   = 2'd3;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    rd;
    logic    fin_pop;
    logic    calc;
    logic    div_start;
    logic    div_take;
    logic    commit;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    empty;
    logic    below_two;
    logic    full;
    logic    top_zero;
    logic    div_done;
    logic    out_free;
  } sts_t;

endpackage

### rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Reverse Polish evaluator on a bounded stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// Each request on the slave channel carries an opcode in tuser (push, add,
// subtract, multiply, divide, finish) and a push value in tdata. Each request
// yields exactly one result on the master channel: the top of the stack (or
// the popped value on finish), the depth and a status code.
// One request is processed at a time. A push, a refused step or a no-op goes
// from decode to the result; add, subtract and multiply read the second
// operand, compute and commit; a finish first reads the next entry when two
// or more remain; a divide waits for the divider, one quotient bit per cycle.
// The next request is accepted in the cycle after the output register loads.
// The output register holds its result while the receiver stalls; the block
// finishes the next request and then waits until the register is free.
// Reset empties the stack and drops any pending result; stack words are not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
  input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] top_value, [39:32] depth
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import pse_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [DataWidth-1:0] top_value;
  logic [7:0]           depth;
  status_t              status;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (s_axis_tuser),
    .operand_value_i (s_axis_tdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .top_value_o     (top_value),
    .depth_o         (depth),
    .status_o        (status)
  );

  assign m_axis_tdata = {depth, top_value};
  assign m_axis_tuser = status;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_OVERFLOW)) |->
      (m_axis_tdata[39:32] == 8'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((STACK_DEPTH < 256) && m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW) &&
     (m_axis_tdata[39:32] == 8'd0)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("empty stack reported with a nonzero top value");

endmodule

### rtl/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Returns the quotient with a done pulse.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pse_pkg::DataWidth-1:0]  dividend_i,
  input  logic [pse_pkg::DataWidth-1:0]  divisor_i,
  output logic                           done_o,
  output logic [pse_pkg::DataWidth-1:0]  quotient_o
);
  import pse_pkg::*;

  localparam int unsigned CntWidth = $clog2(DataWidth + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [DataWidth-1:0] rem_q;
  logic [DataWidth-1:0] quo_q;
  logic [DataWidth-1:0] dvs_q;
  logic                 neg_q;
  logic [DataWidth-1:0] res_q;
  logic [DataWidth:0]   trial;
  logic                 last;

  assign trial = {rem_q, quo_q[DataWidth-1]} - {1'b0, dvs_q};
  assign last  = (cnt_q == CntWidth'(DataWidth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[DataWidth-1] ? (DataWidth'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[DataWidth-1] ? (DataWidth'(0) - divisor_i) : divisor_i;
      neg_q <= dividend_i[DataWidth-1] ^ divisor_i[DataWidth-1];
    end else if (busy_q) begin
      if (last) begin
        res_q <= neg_q ? (DataWidth'(0) - quo_q) : quo_q;
      end else begin
        quo_q <= {quo_q[DataWidth-2:0], ~trial[DataWidth]};
        rem_q <= trial[DataWidth] ? {rem_q[DataWidth-2:0], quo_q[DataWidth-1]}
                                  : trial[DataWidth-1:0];
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = res_q;

endmodule

### rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller of the postfix stack evaluator: sequences one request at a time
// through decode, operand read, arithmetic, stack update and result hand-off.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pse_pkg::sts_t sts_i,
  output pse_pkg::cmd_t cmd_o
);
  import pse_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_READ   = 6'b000100,
    S_DIV    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e state_q;
  state_e state_d;
  cmd_t   cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESULT;
        unique case (sts_i.opcode) inside
          OP_PUSH: begin
            if (sts_i.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sts_i.below_two) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDERFLOW;
            end else if ((sts_i.opcode == OP_DIV) && sts_i.top_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DIVZERO;
            end else begin
              cmd.rd  = 1'b1;
              state_d = S_READ;
            end
          end
          OP_FINISH: begin
            if (sts_i.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDERFLOW;
            end else if (sts_i.below_two) begin
              cmd.fin_pop = 1'b1;
            end else begin
              cmd.rd  = 1'b1;
              state_d = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        if (sts_i.opcode == OP_FINISH) begin
          cmd.fin_pop = 1'b1;
          state_d     = S_RESULT;
        end else if (sts_i.opcode == OP_DIV) begin
          cmd.div_start = 1'b1;
          state_d       = S_DIV;
        end else begin
          cmd.calc = 1'b1;
          state_d  = S_COMMIT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          state_d      = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

### rtl/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Datapath of the postfix stack evaluator: operand stack in RAM with the top
// entry held in a register, adder, multiplier, divider and result register.
// ----------------------------------------------------------------------------
module pse_datapath #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pse_pkg::cmd_t                 cmd_i,
  output pse_pkg::sts_t                 sts_o,
  input  pse_pkg::opcode_t              opcode_i,
  input  logic [pse_pkg::DataWidth-1:0] operand_value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [pse_pkg::DataWidth-1:0] top_value_o,
  output logic [7:0]                    depth_o,
  output pse_pkg::status_t              status_o
);
  import pse_pkg::*;

  localparam int unsigned AddrWidth  = $clog2(STACK_DEPTH);
  localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);

  opcode_t              op_q;
  logic [DataWidth-1:0] val_q;
  logic [CountWidth-1:0] count_q;
  logic [DataWidth-1:0] top_q;
  logic [DataWidth-1:0] res_q;
  logic [DataWidth-1:0] popped_q;
  logic                 pop_q;
  status_t              status_q;
  logic                 out_valid_q;
  logic [DataWidth-1:0] out_top_q;
  logic [7:0]           out_depth_q;
  status_t              out_status_q;

  logic [CountWidth-1:0]   below;
  logic [CountWidth+7:0]   depth_ext;
  logic [DataWidth-1:0]    rdata;
  logic [DataWidth-1:0]    quotient;
  logic                    div_done;
  logic [DataWidth-1:0]    calc_res;
  logic [DataWidth-1:0]    shown;
  logic                    ram_we;
  logic [AddrWidth-1:0]    ram_waddr;
  logic [DataWidth-1:0]    ram_wdata;

  assign below     = count_q - CountWidth'(2);
  assign depth_ext = {8'd0, count_q};

  assign ram_we    = cmd_i.push | cmd_i.commit;
  assign ram_waddr = cmd_i.push ? count_q[AddrWidth-1:0] : below[AddrWidth-1:0];
  assign ram_wdata = cmd_i.push ? val_q : res_q;

  pse_ram #(
    .Width (DataWidth),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (below[AddrWidth-1:0]),
    .rdata_o (rdata)
  );

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rdata),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    case (op_q)
      OP_ADD:  calc_res = rdata + top_q;
      OP_SUB:  calc_res = rdata - top_q;
      OP_MUL:  calc_res = rdata * top_q;
      default: calc_res = '0;
    endcase
  end

  assign shown = pop_q ? popped_q : ((count_q == '0) ? '0 : top_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pop_q       <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pop_q    <= 1'b0;
        status_q <= ST_OK;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.push) begin
        count_q <= count_q + CountWidth'(1);
      end else if (cmd_i.fin_pop || cmd_i.commit) begin
        count_q <= count_q - CountWidth'(1);
      end
      if (cmd_i.fin_pop) begin
        pop_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= operand_value_i;
    end
    if (cmd_i.push) begin
      top_q <= val_q;
    end else if (cmd_i.fin_pop) begin
      top_q <= rdata;
    end else if (cmd_i.commit) begin
      top_q <= res_q;
    end
    if (cmd_i.fin_pop) begin
      popped_q <= top_q;
    end
    if (cmd_i.calc) begin
      res_q <= calc_res;
    end else if (cmd_i.div_take) begin
      res_q <= quotient;
    end
    if (cmd_i.out_load) begin
      out_top_q    <= shown;
      out_depth_q  <= depth_ext[7:0];
      out_status_q <= status_q;
    end
  end

  assign sts_o.opcode    = op_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.below_two = (count_q < CountWidth'(2));
  assign sts_o.full      = (count_q >= CountWidth'(STACK_DEPTH));
  assign sts_o.top_zero  = (top_q == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

endmodule
